// ===== design/mfau_pkg.sv =====
// Shared types and constants for the motor feedback angle unwrap block.
// No dependencies; every other file in the design imports this package.
package mfau_pkg;

  localparam int AngleW = 13;
  localparam int SpeedW = 16;
  localparam int TempW  = 8;
  localparam int CountW = 32;
  localparam int DegW   = 36;
  localparam int SpdQW  = 24;
  localparam int RecipW = 17;

  // Shared multiplier operand and product widths
  localparam int MulAW  = 32;
  localparam int MulBW  = 23;
  localparam int ProdW  = MulAW + MulBW;

  localparam logic [RecipW-1:0] RecipOne = 17'h10000;
  localparam logic signed [MulAW-1:0] DegScale = 32'sd45;

  localparam logic signed [AngleW:0] HalfTurn  = 14'sd4096;
  localparam logic signed [AngleW:0] TurnCount = 14'sd8192;

  localparam logic OpFrame = 1'b0;
  localparam logic OpZero  = 1'b1;

  typedef struct packed {
    logic                     op;
    logic [AngleW-1:0]        angle_raw;
    logic signed [SpeedW-1:0] speed_raw;
    logic [TempW-1:0]         temperature_raw;
  } fb_item_t;

  typedef struct packed {
    logic signed [CountW-1:0] angle_count;
    logic signed [DegW-1:0]   angle_deg_q8;
    logic signed [SpdQW-1:0]  speed_q8;
    logic [TempW-1:0]         temperature;
  } res_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UNWRAP,
    ST_MUL_R,
    ST_MUL_ANG,
    ST_MUL_SPD,
    ST_WRITE
  } seq_state_t;

endpackage

// ===== design/mfau_if.sv =====
// Valid/ready channel interfaces for feedback items and result items.
// Depends on mfau_pkg for the payload structs.
interface mfau_fb_if import mfau_pkg::*; ();
  logic     valid;
  logic     ready;
  fb_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mfau_res_if import mfau_pkg::*; ();
  logic      valid;
  logic      ready;
  res_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/mfau_mul.sv =====
// Shared signed multiplier with a registered product.
// Depends on mfau_pkg for operand widths.
module mfau_mul import mfau_pkg::*; (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [MulAW-1:0] a,
  input  logic signed [MulBW-1:0] b,
  output logic signed [ProdW-1:0] prod
);

  logic signed [ProdW-1:0] prod_next;

  assign prod_next = ProdW'(a) * ProdW'(b);

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= prod_next;
    end
  end

endmodule

// ===== design/motor_feedback_angle_unwrap.sv =====
// Top level: multi-turn angle unwrap and gear-ratio scaling of motor feedback.
// Depends on mfau_pkg, mfau_if (channel interfaces) and mfau_mul.
//
//   channel   | dir | handshake     | payload
//   ----------+-----+---------------+-----------------------------------------
//   feedback  | in  | valid/ready   | op, angle_raw, speed_raw, temperature_raw
//   result    | out | valid/ready   | angle_count, angle_deg_q8, speed_q8,
//             |     |               | temperature
//   cfg       | in  | cfg_we        | cfg_wdata = recip_ratio_q16
//
// A feedback frame goes from acceptance to the result register by one unwrap
// add, three passes through the one shared 32x23 multiplier (45*r, count*45r,
// speed*r) and the result load; a zero request skips the multiplier passes.
// The result register lets the next frame start while a result waits; the
// sequencer holds in its last step while the result register is still full.
// rst clears the sequencer, turn count, last angle and result valid flag.
module motor_feedback_angle_unwrap import mfau_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  mfau_fb_if.sink           feedback,
  mfau_res_if.source        result,
  input  logic              cfg_we,
  input  logic [RecipW-1:0] cfg_wdata
);

  seq_state_t state, state_next;

  logic [RecipW-1:0]        recip;
  logic [RecipW-1:0]        r_eff;
  logic [AngleW-1:0]        last_angle;
  logic signed [CountW-1:0] count;
  logic                     op;
  logic [AngleW-1:0]        angle;
  logic signed [SpeedW-1:0] speed;
  logic [TempW-1:0]         temp;
  logic signed [DegW-1:0]   angle_deg;

  logic                     mul_en;
  logic signed [MulAW-1:0]  mul_a;
  logic signed [MulBW-1:0]  mul_b;
  logic signed [ProdW-1:0]  prod;

  logic signed [AngleW:0]   delta_raw;
  logic signed [AngleW:0]   delta;
  logic                     fb_take;
  logic                     res_load;

  // Saturate the reciprocal at 1.0
  assign r_eff = recip[RecipW-1] ? RecipOne : recip;

  assign fb_take  = feedback.valid && feedback.ready;
  assign res_load = (state == ST_WRITE) && (!result.valid || result.ready);

  always_comb begin
    delta_raw = signed'({1'b0, angle}) - signed'({1'b0, last_angle});
    delta     = delta_raw;
    priority if (delta_raw > HalfTurn) begin
      delta = delta_raw - TurnCount;
    end else if (delta_raw < -HalfTurn) begin
      delta = delta_raw + TurnCount;
    end else begin
      delta = delta_raw;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (feedback.valid) state_next = ST_UNWRAP;
      ST_UNWRAP:  state_next = (op == OpZero) ? ST_WRITE : ST_MUL_R;
      ST_MUL_R:   state_next = ST_MUL_ANG;
      ST_MUL_ANG: state_next = ST_MUL_SPD;
      ST_MUL_SPD: state_next = ST_WRITE;
      ST_WRITE:   if (res_load) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs: multiplier operands and input ready
  always_comb begin
    feedback.ready = 1'b0;
    mul_en         = 1'b0;
    mul_a          = '0;
    mul_b          = '0;
    unique case (state)
      ST_IDLE: begin
        // hold off any transaction while in reset
        feedback.ready = !rst;
      end
      ST_MUL_R: begin
        mul_en = 1'b1;
        mul_a  = DegScale;
        mul_b  = signed'(MulBW'(r_eff));
      end
      ST_MUL_ANG: begin
        // prod holds 45*r, below 2^22, so its low bits are a positive operand
        mul_en = 1'b1;
        mul_a  = count;
        mul_b  = prod[MulBW-1:0];
      end
      ST_MUL_SPD: begin
        mul_en = 1'b1;
        mul_a  = {{(MulAW-SpeedW){speed[SpeedW-1]}}, speed};
        mul_b  = signed'(MulBW'(r_eff));
      end
      default: begin
      end
    endcase
  end

  mfau_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      recip <= RecipOne;
    end else if (cfg_we) begin
      recip <= cfg_wdata;
    end
  end

  // Capture the frame
  always_ff @(posedge clk) begin
    if (fb_take) begin
      op    <= feedback.data.op;
      angle <= feedback.data.angle_raw;
      speed <= feedback.data.speed_raw;
      temp  <= feedback.data.temperature_raw;
    end
  end

  // Unwrap; a zero request clears the count and keeps the last angle
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      last_angle <= '0;
    end else if (state == ST_UNWRAP) begin
      if (op == OpZero) begin
        count <= '0;
      end else begin
        count      <= count + {{(CountW-AngleW-1){delta[AngleW]}}, delta};
        last_angle <= angle;
      end
    end
  end

  // Hold the angle product while the multiplier moves on to the speed
  always_ff @(posedge clk) begin
    if (state == ST_MUL_SPD) begin
      angle_deg <= prod[DegW+17:18];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (res_load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      result.data.angle_count <= count;
      if (op == OpZero) begin
        result.data.angle_deg_q8 <= '0;
        result.data.speed_q8     <= '0;
        result.data.temperature  <= '0;
      end else begin
        result.data.angle_deg_q8 <= angle_deg;
        result.data.speed_q8     <= prod[SpdQW+7:8];
        result.data.temperature  <= temp;
      end
    end
  end

endmodule

// ===== sim/mfau_result_checker.sv =====
`timescale 1ns / 100ps
// Result checker for motor_feedback_angle_unwrap: watches both channels and the config port.
// Predicts each result from its own copy of the turn count and compares field by field.
// Depends on mfau_pkg and mfau_if.
module mfau_result_checker import mfau_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  mfau_fb_if                fb,
  mfau_res_if               res,
  input  logic              cfg_we,
  input  logic [RecipW-1:0] cfg_wdata,
  output int                fail_count,
  output int                pending
);

  localparam int HalfRev = 4096;
  localparam int FullRev = 8192;

  logic [RecipW-1:0]        recip_q16;
  logic [AngleW-1:0]        prev_angle;
  logic signed [CountW-1:0] turn_total;
  res_item_t                expected_results[$];

  // Advance the unwrap state by one transaction and scale by the gear reciprocal.
  function automatic res_item_t unwrap_and_scale(input fb_item_t it);
    res_item_t r;
    int        step;
    longint    gain;
    longint    prod;
    r = '0;
    if (it.op == OpZero) begin
      turn_total = '0;
      return r;
    end
    step = int'(it.angle_raw) - int'(prev_angle);
    if (step > HalfRev) begin
      step -= FullRev;
    end else if (step < -HalfRev) begin
      step += FullRev;
    end
    turn_total = turn_total + step;
    prev_angle = it.angle_raw;
    // Saturate the reciprocal at 1.0
    gain = (recip_q16 > RecipOne) ? longint'(RecipOne) : longint'(recip_q16);
    prod = longint'(turn_total) * 45 * gain;
    r.angle_count  = turn_total;
    r.angle_deg_q8 = DegW'(prod >>> 18);
    prod = longint'(it.speed_raw) * gain;
    r.speed_q8    = SpdQW'(prod >>> 8);
    r.temperature = it.temperature_raw;
    return r;
  endfunction

  task automatic check_field(input string name, input longint want_v, input longint got_v);
    if (want_v != got_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, want_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    res_item_t want;
    res_item_t got;
    if (rst) begin
      recip_q16  = RecipOne;
      prev_angle = '0;
      turn_total = '0;
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        recip_q16 = cfg_wdata;
      end
      if (res.valid && res.ready) begin
        got = res.data;
        if (expected_results.size() == 0) begin
          $error("result transaction with nothing expected: angle_count %0d", got.angle_count);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("angle_count", longint'(want.angle_count), longint'(got.angle_count));
          check_field("angle_deg_q8", longint'(want.angle_deg_q8), longint'(got.angle_deg_q8));
          check_field("speed_q8", longint'(want.speed_q8), longint'(got.speed_q8));
          check_field("temperature", longint'(want.temperature), longint'(got.temperature));
        end
      end
      if (fb.valid && fb.ready) begin
        expected_results.push_back(unwrap_and_scale(fb.data));
      end
    end
    pending = expected_results.size();
  end

endmodule

// ===== sim/motor_feedback_angle_unwrap_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for motor_feedback_angle_unwrap: clock, reset, stimulus and verdict.
// Depends on mfau_pkg, mfau_if, the block itself and mfau_result_checker.
module motor_feedback_angle_unwrap_tb;
  import mfau_pkg::*;

  localparam int IdleLimit   = 2000;
  localparam int PhaseItems  = 200;
  localparam int PhaseCount  = 7;

  bit                clk;
  logic              rst;
  logic              cfg_we;
  logic [RecipW-1:0] cfg_wdata;

  int fail_count;
  int pending;
  int gap_max;
  int stall_max;
  int spin;
  int sent;
  int clears;
  int results;
  int settings;
  int idle_cycles;
  logic [AngleW-1:0] cur_angle;

  mfau_fb_if  fb_ch();
  mfau_res_if res_ch();

  motor_feedback_angle_unwrap uut (
    .clk       (clk),
    .rst       (rst),
    .feedback  (fb_ch.sink),
    .result    (res_ch.source),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  mfau_result_checker chk (
    .clk        (clk),
    .rst        (rst),
    .fb         (fb_ch),
    .res        (res_ch),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Abort when neither channel moves for too long
  always @(posedge clk) begin
    if (res_ch.valid && res_ch.ready) begin
      results <= results + 1;
    end
    if ((fb_ch.valid && fb_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IdleLimit) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: random stall before taking each transaction
  initial begin : result_drain
    int n;
    res_ch.ready <= 1'b0;
    @(negedge clk);
    forever begin
      n = $urandom_range(stall_max, 0);
      if (n > 0) begin
        res_ch.ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!(res_ch.valid && res_ch.ready));
      @(negedge clk);
    end
  end

  task automatic push_item(input fb_item_t it);
    int n;
    n = $urandom_range(gap_max, 0);
    if (n > 0) begin
      fb_ch.valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    fb_ch.data  <= it;
    fb_ch.valid <= 1'b1;
    do @(posedge clk); while (!(fb_ch.valid && fb_ch.ready));
    sent++;
    @(negedge clk);
  endtask

  task automatic send_frame(input logic [AngleW-1:0] a, input logic signed [SpeedW-1:0] s,
                            input logic [TempW-1:0] t);
    fb_item_t it;
    it.op              = OpFrame;
    it.angle_raw       = a;
    it.speed_raw       = s;
    it.temperature_raw = t;
    cur_angle = a;
    push_item(it);
  endtask

  // Clear the count; remaining fields are don't-care, so randomize them
  task automatic send_clear();
    fb_item_t it;
    it.op              = OpZero;
    it.angle_raw       = AngleW'($urandom);
    it.speed_raw       = SpeedW'($urandom);
    it.temperature_raw = TempW'($urandom);
    clears++;
    push_item(it);
  endtask

  task automatic drain();
    fb_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic load_ratio(input logic [RecipW-1:0] v);
    drain();
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
    settings++;
  endtask

  task automatic send_random();
    int                       kind;
    int                       delta;
    logic [AngleW-1:0]        a;
    logic signed [SpeedW-1:0] s;
    kind = $urandom_range(99, 0);
    if (kind < 4) begin
      send_clear();
    end else begin
      if (kind < 30) begin
        a = AngleW'($urandom);
      end else begin
        // steady rotation builds the count; near half-turn steps probe the wrap decision
        if (kind < 80) begin
          delta = spin * int'($urandom_range(2000, 0));
        end else begin
          delta = ($urandom_range(1, 0) ? 1 : -1) * int'($urandom_range(4100, 4090));
        end
        a = cur_angle + AngleW'(delta);
      end
      case ($urandom_range(9, 0))
        0:       s = 16'sh8000;
        1:       s = 16'sh7fff;
        default: s = SpeedW'($urandom);
      endcase
      send_frame(a, s, TempW'($urandom));
    end
  endtask

  initial begin : stimulus
    logic [RecipW-1:0] v;
    rst         <= 1'b1;
    cfg_we      <= 1'b0;
    cfg_wdata   <= '0;
    fb_ch.valid <= 1'b0;
    fb_ch.data  <= '0;
    gap_max   = 3;
    stall_max = 3;
    spin      = 1;
    cur_angle = '0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Reset reciprocal; first frame unwraps against angle zero
    send_frame(13'd0,    16'sh7fff, 8'd255);
    send_frame(13'd8191, 16'sh8000, 8'd0);
    send_frame(13'd4095, -16'sd1,   8'd1);    // step of exactly minus half a turn
    send_frame(13'd0,    16'sd0,    8'd128);
    send_frame(13'd4096, 16'sd1,    8'd254);  // step of exactly plus half a turn
    send_frame(13'd8191, 16'sh7fff, 8'd127);
    send_frame(13'd4095, 16'sh8000, 8'd0);
    send_frame(13'd1,    16'sd255,  8'd255);
    send_frame(13'd4098, -16'sd256, 8'd7);    // just over half a turn wraps back
    send_clear();
    send_frame(13'd4097, 16'sh7fff, 8'd200);  // last angle survives the clear
    send_frame(13'd0,    16'sh8000, 8'd3);

    load_ratio(17'd0);
    send_frame(13'd100,  16'sh8000, 8'd9);
    send_frame(13'd8000, 16'sh7fff, 8'd99);
    load_ratio(17'h1ffff);                    // above 1.0, saturates
    send_frame(13'd8191, 16'sh8000, 8'd255);
    send_frame(13'd50,   -16'sd1,   8'd0);
    load_ratio(17'd1);
    send_frame(13'd4000, 16'sh7fff, 8'd1);
    send_frame(13'd8191, 16'sh8000, 8'd2);
    load_ratio(17'd43690);
    send_frame(13'd12,   16'sd12345, 8'd66);

    for (int p = 0; p < PhaseCount; p++) begin
      case (p)
        0:       v = RecipOne;
        1:       v = 17'd1;
        2:       v = 17'h1ffff;
        3:       v = 17'd0;
        4:       v = 17'd32768;
        5:       v = RecipW'($urandom_range(65536, 1));
        default: v = RecipW'($urandom_range(131071, 0));
      endcase
      load_ratio(v);
      case (p % 3)
        0: begin
          gap_max   = 0;
          stall_max = 0;
        end
        1: begin
          gap_max   = 18;
          stall_max = 18;
        end
        default: begin
          gap_max   = $urandom_range(6, 1);
          stall_max = $urandom_range(18, 1);
        end
      endcase
      spin = (p % 2) ? -1 : 1;
      for (int i = 0; i < PhaseItems; i++) begin
        // hold off mid-phase until the block has emptied
        if (i == PhaseItems / 2 && p == 2) begin
          drain();
        end
        send_random();
      end
    end

    drain();
    repeat (12) @(negedge clk);
    $display("Checked %0d result transactions for %0d feedback transactions, %0d of them clears,",
             results, sent, clears);
    $display("over %0d reciprocal settings including zero, minimum, one and above range.",
             settings);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/mfau_pkg.sv
design/mfau_if.sv
design/mfau_mul.sv
design/motor_feedback_angle_unwrap.sv
sim/mfau_result_checker.sv
sim/motor_feedback_angle_unwrap_tb.sv
